/* sv/doubly_linked_list_engine_core_defines.svh */
// Assertion macros used by the checker of the list engine.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef DOUBLY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define DLLE_ASSERT_CHK(label_name, prop_expr, msg_text) \
    label_name: assert property (@(posedge clk) disable iff (!rst_n) prop_expr) \
        else $error(msg_text);

// A trigger in one cycle implies a condition in the following cycle.
`define DLLE_ASSERT_NEXT(label_name, trig_expr, cons_expr, msg_text) \
    label_name: assert property (@(posedge clk) disable iff (!rst_n) \
        (trig_expr) |=> (cons_expr)) else $error(msg_text);

`endif

/* sv/dlle_pkg.sv */
// Package of the doubly linked list engine: field widths, codes and states.
// Used by the core and the checker.
package dlle_pkg;

    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 3;
    localparam int DATA_W          = 32;
    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_DUMP_FWD  = 3'd3,
        CMD_DUMP_BWD  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_ELEMENT   = 3'd3,
        STS_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_A,
        ST_INS_B,
        ST_DEL_WALK,
        ST_DEL_FIX,
        ST_DUMP_WALK,
        ST_RESP
    } state_t;

endpackage

/* sv/doubly_linked_list_engine_core.sv */
// Top level of the doubly linked list engine: control, pointers and node RAMs.
// Depends on dlle_pkg and dlle_ram.
//
// Channel   Handshake              Payload
// request   in_valid / in_ready    cmd, value
// result    out_valid / out_ready  item_value, status, last
//
// Insert goes through accept, node write (ST_INS_A), link write (ST_INS_B) and result,
// or from accept to result on a full pool. Delete walks to a hit or the end, frees a hit
// node (ST_DEL_FIX) and gives the result; a dump emits each of the N nodes visited (at
// most CAPACITY), or a status result on an empty list. The walk reads one node per cycle,
// unless a dump stalls, on one read address shared by the value, previous and next RAMs.
// After reset the pool is usable at once; per-node written bits stand in for the
// initial free chain. A stalled result register holds the walk in place.
module doubly_linked_list_engine_core
    import dlle_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           cmd,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   item_value,
    output logic [STATUS_W-1:0]        status,
    output logic                       last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PTR_W = $clog2(CAPACITY + 1);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam logic [PTR_W-1:0] NIL = '1;

    // A pointer names a node when it lies below the capacity.
    function automatic logic is_node(input logic [PTR_W-1:0] p);
        return p < PTR_W'(CAPACITY);
    endfunction

    // Control and pointer registers.
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [PTR_W-1:0]       cur_reg, cur_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [PTR_W-1:0]       free_reg, free_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CAPACITY-1:0]    written_reg, written_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    status_t                res_status_reg, res_status_next;

    // Result register.
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      item_value_reg, out_item_next;
    status_t                status_reg, out_status_next;
    logic                   last_reg, out_last_next;
    logic                   out_load;

    // RAM ports.
    logic [IDX_W-1:0]       rd_addr;
    logic                   val_we, prv_we, nxt_we;
    logic [IDX_W-1:0]       val_waddr, prv_waddr, nxt_waddr;
    logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
    logic [PTR_W-1:0]       prv_wdata, prv_rdata, nxt_wdata, nxt_rdata;

    // Shared combinational terms.
    logic                   in_fire, can_emit, pool_full;
    logic [EXT_W-1:0]       in_ext, rd_ext;
    logic [VALUE_WIDTH-1:0] in_word;
    logic [DATA_W-1:0]      rd_item;
    logic [PTR_W-1:0]       rst_next, nxt_eff, prv_eff, walk_next;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   val_match, del_stop, dump_last, front;
    logic [IDX_W-1:0]       cur_idx, head_idx, tail_idx, free_idx;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign pool_full = (used_reg >= CNT_W'(CAPACITY)) || !is_node(free_reg);

    assign cur_idx  = cur_reg[IDX_W-1:0];
    assign head_idx = head_reg[IDX_W-1:0];
    assign tail_idx = tail_reg[IDX_W-1:0];
    assign free_idx = free_reg[IDX_W-1:0];
    assign front    = (cmd_reg == CMD_INS_FRONT);

    // Input word taken to the stored width, sign extended when wider.
    assign in_ext  = EXT_W'(value);
    assign in_word = in_ext[VALUE_WIDTH-1:0];

    // Stored word shown on the 32-bit result field.
    assign rd_ext  = EXT_W'($signed(val_rdata));
    assign rd_item = rd_ext[DATA_W-1:0];

    // A node never written still carries its reset links: free chain and no previous.
    assign rst_next = (rd_idx_reg == IDX_W'(CAPACITY - 1)) ? NIL
                      : PTR_W'(rd_idx_reg) + PTR_W'(1);
    assign nxt_eff  = written_reg[rd_idx_reg] ? nxt_rdata : rst_next;
    assign prv_eff  = written_reg[rd_idx_reg] ? prv_rdata : NIL;

    // Walk terms.
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign walk_next = (cmd_reg == CMD_DUMP_BWD) ? prv_eff : nxt_eff;
    assign val_match = (val_rdata == val_reg);
    assign del_stop  = !is_node(nxt_eff) || (cnt_inc >= CNT_W'(CAPACITY));
    assign dump_last = !is_node(walk_next) || (cnt_inc >= CNT_W'(CAPACITY));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        CMD_INS_FRONT, CMD_INS_BACK:
                            state_next = pool_full ? ST_RESP : ST_INS_A;
                        CMD_DELETE:
                            state_next = is_node(head_reg) ? ST_DEL_WALK : ST_RESP;
                        CMD_DUMP_FWD:
                            state_next = is_node(head_reg) ? ST_DUMP_WALK : ST_RESP;
                        CMD_DUMP_BWD:
                            state_next = is_node(tail_reg) ? ST_DUMP_WALK : ST_RESP;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_A:
                state_next = ST_INS_B;
            ST_INS_B:
                state_next = ST_RESP;
            ST_DEL_WALK:
            begin
                if (val_match)
                begin
                    state_next = ST_DEL_FIX;
                end
                else if (del_stop)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DEL_FIX:
                state_next = ST_RESP;
            ST_DUMP_WALK:
            begin
                if (can_emit && dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM accesses and result loading.
    always_comb
    begin
        rd_addr         = '0;
        val_we          = 1'b0;
        val_waddr       = cur_idx;
        val_wdata       = val_reg;
        prv_we          = 1'b0;
        prv_waddr       = cur_idx;
        prv_wdata       = NIL;
        nxt_we          = 1'b0;
        nxt_waddr       = cur_idx;
        nxt_wdata       = NIL;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        used_next       = used_reg;
        written_next    = written_reg;
        res_status_next = res_status_reg;
        out_load        = 1'b0;
        out_item_next   = '0;
        out_status_next = STS_DONE;
        out_last_next   = 1'b1;

        unique case (state_reg)
            // Take a request and start the first RAM read.
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next = cmd_t'(cmd);
                    val_next = in_word;
                    cnt_next = '0;
                    unique case (cmd)
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            cur_next        = free_reg;
                            res_status_next = pool_full ? STS_FULL : STS_DONE;
                            if (!pool_full)
                            begin
                                rd_addr = free_idx;
                            end
                        end
                        CMD_DELETE:
                        begin
                            cur_next        = head_reg;
                            res_status_next = STS_NOT_FOUND;
                            if (is_node(head_reg))
                            begin
                                rd_addr = head_idx;
                            end
                        end
                        CMD_DUMP_FWD:
                        begin
                            cur_next        = head_reg;
                            res_status_next = STS_EMPTY;
                            if (is_node(head_reg))
                            begin
                                rd_addr = head_idx;
                            end
                        end
                        CMD_DUMP_BWD:
                        begin
                            cur_next        = tail_reg;
                            res_status_next = STS_EMPTY;
                            if (is_node(tail_reg))
                            begin
                                rd_addr = tail_idx;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Fill the new node and pop it off the free list.
            ST_INS_A:
            begin
                val_we    = 1'b1;
                prv_we    = 1'b1;
                prv_wdata = front ? NIL : tail_reg;
                nxt_we    = 1'b1;
                nxt_wdata = front ? head_reg : NIL;
                free_next = nxt_eff;
                used_next = used_reg + CNT_W'(1);
                written_next[cur_idx] = 1'b1;
            end

            // Link the neighbor to the new node and move head or tail.
            ST_INS_B:
            begin
                if (front)
                begin
                    if (is_node(head_reg))
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = head_idx;
                        prv_wdata = cur_reg;
                    end
                    else
                    begin
                        tail_next = cur_reg;
                    end
                    head_next = cur_reg;
                end
                else
                begin
                    if (is_node(tail_reg))
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = tail_idx;
                        nxt_wdata = cur_reg;
                    end
                    else
                    begin
                        head_next = cur_reg;
                    end
                    tail_next = cur_reg;
                end
            end

            // Compare one node per cycle; on a hit bypass it in both directions.
            ST_DEL_WALK:
            begin
                if (val_match)
                begin
                    res_status_next = STS_DONE;
                    if (is_node(prv_eff))
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_eff[IDX_W-1:0];
                        nxt_wdata = nxt_eff;
                    end
                    else
                    begin
                        head_next = nxt_eff;
                    end
                    if (is_node(nxt_eff))
                    begin
                        prv_we    = 1'b1;
                        prv_waddr = nxt_eff[IDX_W-1:0];
                        prv_wdata = prv_eff;
                    end
                    else
                    begin
                        tail_next = prv_eff;
                    end
                end
                else if (!del_stop)
                begin
                    rd_addr  = nxt_eff[IDX_W-1:0];
                    cur_next = nxt_eff;
                    cnt_next = cnt_inc;
                end
            end

            // Push the removed node onto the free list.
            ST_DEL_FIX:
            begin
                prv_we    = 1'b1;
                prv_wdata = NIL;
                nxt_we    = 1'b1;
                nxt_wdata = free_reg;
                free_next = cur_reg;
                if (used_reg != '0)
                begin
                    used_next = used_reg - CNT_W'(1);
                end
            end

            // Emit one element per cycle; hold the node read while the result stalls.
            ST_DUMP_WALK:
            begin
                if (can_emit)
                begin
                    out_load        = 1'b1;
                    out_item_next   = rd_item;
                    out_status_next = STS_ELEMENT;
                    out_last_next   = dump_last;
                    if (!dump_last)
                    begin
                        rd_addr  = walk_next[IDX_W-1:0];
                        cur_next = walk_next;
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    rd_addr = cur_idx;
                end
            end

            // Single status result.
            ST_RESP:
            begin
                if (can_emit)
                begin
                    out_load        = 1'b1;
                    out_status_next = res_status_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            free_reg      <= '0;
            used_reg      <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            used_reg    <= used_next;
            written_reg <= written_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        rd_idx_reg     <= rd_addr;
        if (out_load)
        begin
            item_value_reg <= out_item_next;
            status_reg     <= out_status_next;
            last_reg       <= out_last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign item_value = item_value_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // Node value store.
    dlle_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_wdata),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    // Previous links.
    dlle_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_prv_ram (
        .clk     (clk),
        .wr_en   (prv_we),
        .wr_addr (prv_waddr),
        .wr_data (prv_wdata),
        .rd_addr (rd_addr),
        .rd_data (prv_rdata)
    );

    // Next links, which also chain the free list.
    dlle_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_nxt_ram (
        .clk     (clk),
        .wr_en   (nxt_we),
        .wr_addr (nxt_waddr),
        .wr_data (nxt_wdata),
        .rd_addr (rd_addr),
        .rd_data (nxt_rdata)
    );

endmodule

/* sv/dlle_ram.sv */
// Generic simple dual port RAM: one write port, one read port, registered read.
// Depends on nothing.
module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/dlle_checker.sv */
// Port-level checker of the list engine, bound to the top level.
// Depends on dlle_pkg and doubly_linked_list_engine_core_defines.svh.
`include "doubly_linked_list_engine_core_defines.svh"

module dlle_checker
    import dlle_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [CMD_W-1:0]         cmd,
    input logic signed [DATA_W-1:0] value,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] item_value,
    input logic [STATUS_W-1:0]      status,
    input logic                     last
);

    // A stalled result keeps its contents.
    `DLLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(item_value) && $stable(status) && $stable(last), "result changed while stalled")

    // Status results are single, final and carry no element.
    `DLLE_ASSERT_CHK(a_status_form, (out_valid && status != STS_ELEMENT) |-> (last && item_value == 0), "status result malformed")

    // An accepted insert or delete request always leaves the engine not ready for a new request.
    `DLLE_ASSERT_NEXT(a_busy_after_update, in_valid && in_ready && (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK || cmd == CMD_DELETE), !in_ready, "new request taken during update")

    // The element after a non-final one follows directly once the former leaves.
    `DLLE_ASSERT_NEXT(a_dump_busy, out_valid && out_ready && status == STS_ELEMENT && !last, out_valid && status == STS_ELEMENT, "dump element missing after a non-final one")

    // Nothing is taken while a dump is only partly through.
    `DLLE_ASSERT_CHK(a_elem_not_idle, (out_valid && status == STS_ELEMENT && !last) |-> !in_ready, "engine idle before final element")

endmodule

bind doubly_linked_list_engine_core dlle_checker u_dlle_checker (.*);
